// ===== src/exl_pkg.sv =====
// exl_pkg: shared types, character and token codes, and helpers for the
// expression lexer. No dependencies; every other file imports this package.
`default_nettype none

package exl_pkg;

	localparam int POS_W  = 20;
	localparam int KIND_W = 5;
	localparam int CHAR_W = 8;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic [2:0] {
		PK_NONE = 3'd0,
		PK_BANG = 3'd1,
		PK_AMP  = 3'd2,
		PK_BAR  = 3'd3,
		PK_LT   = 3'd4,
		PK_GT   = 3'd5,
		PK_EQ   = 3'd6,
		PK_NUM  = 3'd7
	} pend_t;

	typedef enum logic [KIND_W-1:0] {
		TK_OPAREN = 5'd0,
		TK_CPAREN = 5'd1,
		TK_PLUS   = 5'd2,
		TK_MINUS  = 5'd3,
		TK_STAR   = 5'd4,
		TK_SLASH  = 5'd5,
		TK_LT     = 5'd6,
		TK_GT     = 5'd7,
		TK_LE     = 5'd8,
		TK_GE     = 5'd9,
		TK_ASSIGN = 5'd10,
		TK_EQEQ   = 5'd11,
		TK_NE     = 5'd12,
		TK_NOT    = 5'd13,
		TK_AND    = 5'd14,
		TK_OR     = 5'd15,
		TK_NUMBER = 5'd16,
		TK_EOF    = 5'd17,
		TK_ERROR  = 5'd18
	} tok_kind_t;

	localparam char_t CH_NUL    = 8'h00;
	localparam char_t CH_TAB    = 8'h09;
	localparam char_t CH_LF     = 8'h0A;
	localparam char_t CH_CR     = 8'h0D;
	localparam char_t CH_SP     = 8'h20;
	localparam char_t CH_BANG   = 8'h21;
	localparam char_t CH_AMP    = 8'h26;
	localparam char_t CH_OPAREN = 8'h28;
	localparam char_t CH_CPAREN = 8'h29;
	localparam char_t CH_STAR   = 8'h2A;
	localparam char_t CH_PLUS   = 8'h2B;
	localparam char_t CH_MINUS  = 8'h2D;
	localparam char_t CH_SLASH  = 8'h2F;
	localparam char_t CH_ZERO   = 8'h30;
	localparam char_t CH_NINE   = 8'h39;
	localparam char_t CH_LT     = 8'h3C;
	localparam char_t CH_EQ     = 8'h3D;
	localparam char_t CH_GT     = 8'h3E;
	localparam char_t CH_BAR    = 8'h7C;

	typedef struct packed {
		logic      vld;
		tok_kind_t kind;
		pos_t      start;
		pos_t      len;
		pos_t      line;
		logic      last;
	} tok_rec_t;

	typedef struct packed {
		logic not_empty;
		logic no_room;
	} q_stat_t;

	function automatic pos_t sat_inc(input pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	function automatic tok_rec_t mk_tok(input tok_kind_t kind, input pos_t start,
			input pos_t len, input pos_t line);
		tok_rec_t t;
		t.vld   = 1'b1;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.line  = line;
		t.last  = 1'b0;
		return t;
	endfunction

	function automatic tok_kind_t single_kind(input pend_t pk);
		tok_kind_t k;
		unique case (pk)
			PK_BANG: k = TK_NOT;
			PK_LT:   k = TK_LT;
			PK_GT:   k = TK_GT;
			PK_EQ:   k = TK_ASSIGN;
			default: k = TK_ERROR;
		endcase
		return k;
	endfunction

	function automatic tok_kind_t pair_kind(input pend_t pk);
		tok_kind_t k;
		unique case (pk)
			PK_BANG: k = TK_NE;
			PK_AMP:  k = TK_AND;
			PK_BAR:  k = TK_OR;
			PK_LT:   k = TK_LE;
			PK_GT:   k = TK_GE;
			PK_EQ:   k = TK_EQEQ;
			default: k = TK_ERROR;
		endcase
		return k;
	endfunction

	function automatic char_t pair_char(input pend_t pk);
		char_t c;
		unique case (pk)
			PK_BANG, PK_LT, PK_GT, PK_EQ: c = CH_EQ;
			PK_AMP:  c = CH_AMP;
			PK_BAR:  c = CH_BAR;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/exl_scan.sv =====
// exl_scan: scanner state (pending operator or digit run, position, line)
// and token formation for one byte. Uses exl_pkg.
`default_nettype none

module exl_scan (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire exl_pkg::char_t   char_code,
	output exl_pkg::tok_rec_t     tok_a,
	output exl_pkg::tok_rec_t     tok_b
);
	import exl_pkg::*;

	pend_t    pend_q, pend_n;
	pos_t     pstart_q, pstart_n;
	pos_t     dcnt_q, dcnt_n;
	pos_t     bpos_q, bpos_n;
	pos_t     line_q, line_n;
	logic     consumed;
	logic     digit_c;
	tok_rec_t ta, tb;

	always_comb begin
		ta       = '0;
		tb       = '0;
		consumed = 1'b0;
		pend_n   = pend_q;
		pstart_n = pstart_q;
		dcnt_n   = dcnt_q;
		bpos_n   = sat_inc(bpos_q);
		line_n   = line_q;
		digit_c  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

		// resolve whatever the previous byte left open
		if (pend_q == PK_NUM) begin
			if (digit_c) begin
				dcnt_n   = sat_inc(dcnt_q);
				consumed = 1'b1;
			end else begin
				ta     = mk_tok(TK_NUMBER, pstart_q, dcnt_q, line_q);
				pend_n = PK_NONE;
				dcnt_n = '0;
			end
		end else if (pend_q != PK_NONE) begin
			if (char_code != CH_NUL && char_code == pair_char(pend_q)) begin
				ta       = mk_tok(pair_kind(pend_q), pstart_q, pos_t'(2), line_q);
				consumed = 1'b1;
			end else if (pend_q != PK_AMP && pend_q != PK_BAR) begin
				ta = mk_tok(single_kind(pend_q), pstart_q, pos_t'(1), line_q);
			end
			pend_n = PK_NONE;
		end

		if (!consumed) begin
			unique case (char_code)
				CH_OPAREN: tb = mk_tok(TK_OPAREN, bpos_q, pos_t'(1), line_q);
				CH_CPAREN: tb = mk_tok(TK_CPAREN, bpos_q, pos_t'(1), line_q);
				CH_PLUS:   tb = mk_tok(TK_PLUS,   bpos_q, pos_t'(1), line_q);
				CH_MINUS:  tb = mk_tok(TK_MINUS,  bpos_q, pos_t'(1), line_q);
				CH_STAR:   tb = mk_tok(TK_STAR,   bpos_q, pos_t'(1), line_q);
				CH_SLASH:  tb = mk_tok(TK_SLASH,  bpos_q, pos_t'(1), line_q);
				CH_BANG: begin
					pend_n   = PK_BANG;
					pstart_n = bpos_q;
				end
				CH_AMP: begin
					pend_n   = PK_AMP;
					pstart_n = bpos_q;
				end
				CH_BAR: begin
					pend_n   = PK_BAR;
					pstart_n = bpos_q;
				end
				CH_LT: begin
					pend_n   = PK_LT;
					pstart_n = bpos_q;
				end
				CH_GT: begin
					pend_n   = PK_GT;
					pstart_n = bpos_q;
				end
				CH_EQ: begin
					pend_n   = PK_EQ;
					pstart_n = bpos_q;
				end
				CH_SP, CH_TAB, CH_CR: ;
				CH_LF: line_n = sat_inc(line_q);
				CH_NUL: begin
					// end of text: next byte starts a fresh text
					tb       = mk_tok(TK_EOF, bpos_q, pos_t'(1), line_q);
					pend_n   = PK_NONE;
					pstart_n = '0;
					dcnt_n   = '0;
					bpos_n   = '0;
					line_n   = pos_t'(1);
				end
				default: begin
					if (digit_c) begin
						pend_n   = PK_NUM;
						pstart_n = bpos_q;
						dcnt_n   = pos_t'(1);
					end else begin
						tb = mk_tok(TK_ERROR, bpos_q, pos_t'(1), line_q);
					end
				end
			endcase
		end

		if (tb.vld) begin
			tb.last = 1'b1;
		end else begin
			ta.last = ta.vld;
		end
	end

	assign tok_a = ta;
	assign tok_b = tb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= PK_NONE;
			pstart_q <= '0;
			dcnt_q   <= '0;
			bpos_q   <= '0;
			line_q   <= pos_t'(1);
		end else if (fire) begin
			pend_q   <= pend_n;
			pstart_q <= pstart_n;
			dcnt_q   <= dcnt_n;
			bpos_q   <= bpos_n;
			line_q   <= line_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/exl_outq.sv =====
// exl_outq: small token queue that takes up to two tokens per cycle and
// hands out one. Uses exl_pkg.
`default_nettype none

module exl_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire exl_pkg::tok_rec_t tok_a,
	input  wire exl_pkg::tok_rec_t tok_b,
	input  wire logic              pop,
	output exl_pkg::tok_rec_t      head,
	output exl_pkg::q_stat_t       stat
);
	import exl_pkg::*;

	tok_rec_t            mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                wa, wb;
	logic [1:0]          n_push;

	assign wa     = fire && tok_a.vld;
	assign wb     = fire && tok_b.vld;
	assign n_push = {1'b0, wa} + {1'b0, wb};

	always_ff @(posedge clk) begin
		if (wa || wb) begin
			mem[wr_q] <= wa ? tok_a : tok_b;
		end
		if (wa && wb) begin
			mem[wr_q + QPTR_W'(1)] <= tok_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(n_push);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

	assign head           = mem[rd_q];
	assign stat.not_empty = (cnt_q != '0);
	// keep room for the two tokens one byte can raise
	assign stat.no_room   = (cnt_q > QCNT_W'(QDEPTH - 2));

endmodule

`default_nettype wire

// ===== src/expression_lexer_top.sv =====
// expression_lexer_top: top level of the expression lexer.
// Depends on exl_pkg, exl_scan and exl_outq.
//
// Usage:
//  Input channel (in_valid/in_stall/char_code) takes one source byte per
//  request; byte 0 ends the text and resets position and line for the next.
//  Output channel (out_valid/out_stall/token fields) gives one token per
//  request; last_of_run marks the final token raised by a byte.
//  A token raised by a byte enters the token queue when the byte is taken and
//  reaches the output behind earlier tokens. Throughput: one byte per cycle
//  while in_stall is low; a four-entry token queue absorbs two-token bytes.
//  in_stall is high while the queue holds more than two tokens, so it
//  depends only on registered queue state. When the receiver stalls, the
//  head token holds still and the queue fills until in_stall rises.
//  Reset empties the queue, clears any pending token, sets the byte
//  position to 0 and the line to 1.
`default_nettype none

module expression_lexer_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [exl_pkg::CHAR_W-1:0]   char_code,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [exl_pkg::KIND_W-1:0]        token_kind,
	output logic [exl_pkg::POS_W-1:0]         start_offset,
	output logic [exl_pkg::POS_W-1:0]         token_length,
	output logic [exl_pkg::POS_W-1:0]         line_number,
	output logic                              last_of_run
);
	import exl_pkg::*;

	tok_rec_t tok_a, tok_b, head;
	q_stat_t  stat;
	logic     fire, pop;

	assign in_stall  = stat.no_room;
	assign fire      = in_valid && !in_stall;
	assign out_valid = stat.not_empty;
	assign pop       = out_valid && !out_stall;

	exl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (char_code),
		.tok_a     (tok_a),
		.tok_b     (tok_b)
	);

	exl_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.tok_a  (tok_a),
		.tok_b  (tok_b),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	assign token_kind   = head.kind;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign line_number  = head.line;
	assign last_of_run  = head.last;

endmodule

`default_nettype wire

// ===== src/exl_chk.sv =====
// exl_chk: port-level checks for expression_lexer_top, bound to it below.
// Depends on exl_pkg.
`default_nettype none

module exl_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic [exl_pkg::CHAR_W-1:0] char_code,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [exl_pkg::KIND_W-1:0] token_kind,
	input wire logic [exl_pkg::POS_W-1:0]  start_offset,
	input wire logic [exl_pkg::POS_W-1:0]  token_length,
	input wire logic [exl_pkg::POS_W-1:0]  line_number,
	input wire logic                       last_of_run
);
	import exl_pkg::*;

	// a stalled byte request stays put
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(char_code))
		else $error("byte request changed while stalled");

	// a held token must not change under the receiver
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind)
			&& $stable(start_offset) && $stable(token_length)
			&& $stable(line_number) && $stable(last_of_run))
		else $error("token changed while stalled");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == TK_EOF |-> last_of_run)
		else $error("eof token not last of its byte");

	a_pair_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == TK_LE || token_kind == TK_GE
			|| token_kind == TK_EQEQ || token_kind == TK_NE
			|| token_kind == TK_AND || token_kind == TK_OR)
		|-> token_length == POS_W'(2))
		else $error("two-character operator with wrong length");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_length != '0 && line_number != '0)
		else $error("zero length or line on token");

endmodule

bind expression_lexer_top exl_chk u_exl_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.char_code    (char_code),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.token_kind   (token_kind),
	.start_offset (start_offset),
	.token_length (token_length),
	.line_number  (line_number),
	.last_of_run  (last_of_run)
);

`default_nettype wire
